>>> design/mp3hd_pkg.sv
package mp3hd_pkg;

    localparam logic [1:0] VER_25   = 2'd0;
    localparam logic [1:0] VER_RSVD = 2'd1;
    localparam logic [1:0] VER_2    = 2'd2;
    localparam logic [1:0] VER_1    = 2'd3;

    localparam logic [1:0] LAYER_III = 2'd1;

    localparam logic [3:0] BRI_FREE = 4'd0;
    localparam logic [3:0] BRI_BAD  = 4'd15;

    localparam logic [1:0] SRI_44K  = 2'd0;
    localparam logic [1:0] SRI_48K  = 2'd1;
    localparam logic [1:0] SRI_32K  = 2'd2;
    localparam logic [1:0] SRI_RSVD = 2'd3;

    localparam logic [10:0] SPF_V1 = 11'd1152;
    localparam logic [10:0] SPF_V2 = 11'd576;

    // 160*x/49 via reciprocal, exact for x*160 < 89240
    localparam int          DIV49_SHIFT = 22;
    localparam logic [16:0] DIV49_RECIP = 17'd85599;
    localparam logic [16:0] DIVISOR_49  = 17'd49;

    localparam logic [8:0] KBPS_V1 [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
    };
    localparam logic [8:0] KBPS_V2 [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0
    };

    typedef struct packed {
        logic        ok;
        logic        hit;
        logic [1:0]  ver;
        logic [8:0]  kbps;
        logic [15:0] hz;
        logic [10:0] spf;
        logic        pad;
        logic [1:0]  sri;
        logic [8:0]  x;
    } t_dec;

    function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [3:0] bri);
        logic [8:0] k;
        case (ver)
            VER_1:        k = KBPS_V1[bri];
            VER_2, VER_25: k = KBPS_V2[bri];
            default:      k = 9'd0;
        endcase
        return k;
    endfunction

    function automatic logic [15:0] hz_lookup(input logic [1:0] ver, input logic [1:0] sri);
        logic [15:0] h;
        h = 16'd0;
        case (ver)
            VER_1: begin
                case (sri)
                    SRI_44K: h = 16'd44100;
                    SRI_48K: h = 16'd48000;
                    SRI_32K: h = 16'd32000;
                    default: h = 16'd0;
                endcase
            end
            VER_2: begin
                case (sri)
                    SRI_44K: h = 16'd22050;
                    SRI_48K: h = 16'd24000;
                    SRI_32K: h = 16'd16000;
                    default: h = 16'd0;
                endcase
            end
            VER_25: begin
                case (sri)
                    SRI_44K: h = 16'd11025;
                    SRI_48K: h = 16'd12000;
                    SRI_32K: h = 16'd8000;
                    default: h = 16'd0;
                endcase
            end
            default: h = 16'd0;
        endcase
        return h;
    endfunction

endpackage

>>> design/mp3hd_decode.sv
module mp3hd_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [31:0]         i_header_word,
    input  logic [8:0]          i_target,
    output logic                o_v,
    output mp3hd_pkg::t_dec     o_dec
);
    import mp3hd_pkg::*;

    logic [1:0] ver;
    logic [1:0] layer;
    logic [3:0] bri;
    logic [1:0] sri;
    t_dec       n_dec;
    t_dec       r_dec;
    logic       r_v;

    assign ver   = i_header_word[20:19];
    assign layer = i_header_word[18:17];
    assign bri   = i_header_word[15:12];
    assign sri   = i_header_word[11:10];

    always_comb begin
        n_dec.ver  = ver;
        n_dec.kbps = kbps_lookup(ver, bri);
        n_dec.hz   = hz_lookup(ver, sri);
        n_dec.spf  = (ver == VER_1) ? SPF_V1 : ((ver == VER_RSVD) ? 11'd0 : SPF_V2);
        n_dec.pad  = i_header_word[9];
        n_dec.sri  = sri;
        n_dec.ok   = (ver != VER_RSVD) && (layer == LAYER_III) && (bri != BRI_FREE)
                     && (bri != BRI_BAD) && (sri != SRI_RSVD);
        n_dec.hit  = (i_target == 9'd0) || (n_dec.kbps == i_target);
        // MPEG2.5 rates are a quarter of the MPEG1 family: double the bitrate term
        n_dec.x    = (ver == VER_25) ? {n_dec.kbps[7:0], 1'b0} : n_dec.kbps;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec <= n_dec;
    end

    assign o_v   = r_v;
    assign o_dec = r_dec;

endmodule

>>> design/mp3hd_len_div.sv
module mp3hd_len_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_v,
    input  mp3hd_pkg::t_dec     i_dec,
    output logic                o_v,
    output mp3hd_pkg::t_dec     o_dec,
    output logic [10:0]         o_len_base
);
    import mp3hd_pkg::*;

    // stage 2: 160*x times reciprocal of 49, plus exact 48k / 32k forms
    logic [15:0] y;
    logic [32:0] prod;
    logic [10:0] alt;
    logic [12:0] x9;
    logic [15:0] r_y;
    logic [32:0] r_prod;
    logic [10:0] r_alt;
    t_dec        r_dec2;
    logic        r_v2;

    function automatic logic [15:0] x_ext(input logic [8:0] v);
        return {7'd0, v};
    endfunction

    assign y    = {x_ext(i_dec.x) << 7} + {x_ext(i_dec.x) << 5};
    assign prod = {17'd0, y} * {16'd0, DIV49_RECIP};
    assign x9   = {1'b0, i_dec.x, 3'b000} + {4'd0, i_dec.x};
    assign alt  = (i_dec.sri == SRI_48K) ?
                  ({2'b00, i_dec.x} + {1'b0, i_dec.x, 1'b0}) : x9[11:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y    <= y;
        r_prod <= prod;
        r_alt  <= alt;
        r_dec2 <= i_dec;
    end

    // stage 3: quotient, one-step correction, rate select
    logic [10:0] q;
    logic [16:0] q49;
    logic [16:0] rem;
    logic [10:0] qc;
    logic [10:0] n_base;
    logic [10:0] r_base;
    t_dec        r_dec3;
    logic        r_v3;

    assign q      = r_prod[DIV49_SHIFT +: 11];
    assign q49    = {1'b0, q, 5'b0} + {2'b0, q, 4'b0} + {6'd0, q};
    assign rem    = {1'b0, r_y} - q49;
    assign qc     = (rem >= DIVISOR_49) ? q + 11'd1 : q;
    assign n_base = (r_dec2.sri == SRI_44K) ? qc : r_alt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_dec3 <= r_dec2;
    end

    assign o_v        = r_v3;
    assign o_dec      = r_dec3;
    assign o_len_base = r_base;

endmodule

>>> design/mp3_header_decode_core.sv
// channel | ports                                   | beat
// --------+-----------------------------------------+-------------------------------
// cfg     | i_cfg_wr_en, i_cfg_wr_data[8:0]         | edge with i_cfg_wr_en high
// in      | i_start, o_busy, i_header_word[31:0]    | edge with i_start & !o_busy
// out     | o_strobe + seven result fields          | one cycle with o_strobe high
//
// Four register stages: decode/lookup, reciprocal multiply, quotient
// correction and rate select, output register. A new header each cycle;
// o_busy is never raised. Synchronous reset clears the stage valid bits
// and the target register. The receiver cannot stall; results are shown
// for exactly one cycle.
module mp3_header_decode_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_header_word,
    output logic        o_strobe,
    output logic        o_header_valid,
    output logic [1:0]  o_version_code,
    output logic [8:0]  o_bitrate_kbps,
    output logic [15:0] o_sample_rate_hz,
    output logic [10:0] o_samples_per_frame,
    output logic        o_padded,
    output logic [10:0] o_frame_length_bytes
);
    import mp3hd_pkg::*;

    logic [8:0]  r_target;
    logic        take;
    logic        v1;
    t_dec        dec1;
    logic        v3;
    t_dec        dec3;
    logic [10:0] len_base;

    logic        r_strobe;
    logic        r_header_valid;
    logic [1:0]  r_version_code;
    logic [8:0]  r_bitrate_kbps;
    logic [15:0] r_sample_rate_hz;
    logic [10:0] r_samples_per_frame;
    logic        r_padded;
    logic [10:0] r_frame_length_bytes;
    logic [10:0] n_frame_length_bytes;

    assign o_busy = 1'b0;
    assign take   = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 9'd0;
        end else if (i_cfg_wr_en) begin
            r_target <= i_cfg_wr_data;
        end
    end

    mp3hd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_header_word (i_header_word),
        .i_target      (r_target),
        .o_v           (v1),
        .o_dec         (dec1)
    );

    mp3hd_len_div u_len_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_v        (v1),
        .i_dec      (dec1),
        .o_v        (v3),
        .o_dec      (dec3),
        .o_len_base (len_base)
    );

    assign n_frame_length_bytes = dec3.ok ? (len_base + {10'd0, dec3.pad}) : 11'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_header_valid       <= dec3.ok && dec3.hit;
        r_version_code       <= dec3.ver;
        r_bitrate_kbps       <= dec3.kbps;
        r_sample_rate_hz     <= dec3.hz;
        r_samples_per_frame  <= dec3.spf;
        r_padded             <= dec3.pad;
        r_frame_length_bytes <= n_frame_length_bytes;
    end

    assign o_strobe             = r_strobe;
    assign o_header_valid       = r_header_valid;
    assign o_version_code       = r_version_code;
    assign o_bitrate_kbps       = r_bitrate_kbps;
    assign o_sample_rate_hz     = r_sample_rate_hz;
    assign o_samples_per_frame  = r_samples_per_frame;
    assign o_padded             = r_padded;
    assign o_frame_length_bytes = r_frame_length_bytes;

endmodule

>>> design/mp3hd_chk.sv
module mp3hd_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,
    input  logic        i_start,
    input  logic        o_busy,
    input  logic [31:0] i_header_word,
    input  logic        o_strobe,
    input  logic        o_header_valid,
    input  logic [1:0]  o_version_code,
    input  logic [8:0]  o_bitrate_kbps,
    input  logic [15:0] o_sample_rate_hz,
    input  logic [10:0] o_samples_per_frame,
    input  logic        o_padded,
    input  logic [10:0] o_frame_length_bytes
);

    a_beat_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##4 o_strobe)
        else $error("input beat without result four cycles later");

    a_result_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start, 4))
        else $error("result without a matching input beat");

    a_valid_has_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_header_valid) |-> (o_frame_length_bytes != 11'd0))
        else $error("valid header with zero frame length");

    a_len_has_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_frame_length_bytes != 11'd0) |->
            (o_sample_rate_hz != 16'd0 && o_samples_per_frame != 11'd0
             && o_bitrate_kbps != 9'd0))
        else $error("frame length from a reserved or free header");

endmodule

bind mp3_header_decode_core mp3hd_chk u_mp3hd_chk (.*);

>>> bench/mp3hd_header_checker.sv
`timescale 1ns / 1ps

module mp3hd_header_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_header_word,
    input  logic        i_strobe,
    input  logic        i_header_valid,
    input  logic [1:0]  i_version_code,
    input  logic [8:0]  i_bitrate_kbps,
    input  logic [15:0] i_sample_rate_hz,
    input  logic [10:0] i_samples_per_frame,
    input  logic        i_padded,
    input  logic [10:0] i_frame_length_bytes,
    output int          o_fail_count,
    output int          o_pending
);
    import mp3hd_pkg::*;

    typedef struct packed {
        logic        valid;
        logic [1:0]  ver;
        logic [8:0]  kbps;
        logic [15:0] hz;
        logic [10:0] spf;
        logic        pad;
        logic [10:0] len;
    } t_frame_info;

    localparam logic [8:0] MPEG1_KBPS [16] = '{
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0
    };
    localparam logic [8:0] MPEG2_KBPS [16] = '{
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0
    };
    localparam logic [15:0] MPEG1_HZ  [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};
    localparam logic [15:0] MPEG2_HZ  [4] = '{16'd22050, 16'd24000, 16'd16000, 16'd0};
    localparam logic [15:0] MPEG25_HZ [4] = '{16'd11025, 16'd12000, 16'd8000, 16'd0};

    logic [8:0]  target_kbps;
    t_frame_info decoded_q[$];

    function automatic t_frame_info decode_header(input logic [31:0] w, input logic [8:0] target);
        t_frame_info     f;
        logic [1:0]      layer;
        logic [1:0]      sri;
        logic [3:0]      bri;
        logic            well_formed;
        longint unsigned num;
        longint unsigned den;
        f     = '0;
        f.ver = w[20:19];
        layer = w[18:17];
        bri   = w[15:12];
        sri   = w[11:10];
        f.pad = w[9];
        case (f.ver)
            VER_1: begin
                f.kbps = MPEG1_KBPS[bri];
                f.hz   = MPEG1_HZ[sri];
                f.spf  = 11'd1152;
            end
            VER_2: begin
                f.kbps = MPEG2_KBPS[bri];
                f.hz   = MPEG2_HZ[sri];
                f.spf  = 11'd576;
            end
            VER_25: begin
                f.kbps = MPEG2_KBPS[bri];
                f.hz   = MPEG25_HZ[sri];
                f.spf  = 11'd576;
            end
            default: begin
            end
        endcase
        well_formed = f.ver != VER_RSVD && layer == LAYER_III && bri != BRI_FREE &&
                      bri != BRI_BAD && sri != SRI_RSVD;
        if (well_formed && f.hz != 16'd0) begin
            num   = longint'(f.spf) * 64'd1000 * longint'(f.kbps);
            den   = 64'd8 * longint'(f.hz);
            f.len = 11'(num / den + longint'(f.pad));
        end
        f.valid = well_formed && (target == 9'd0 || f.kbps == target);
        return f;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_info want;
        if (!i_rst_n) begin
            target_kbps <= '0;
            decoded_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_strobe) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t result beat with nothing expected, frame length %0d",
                             $time, i_frame_length_bytes);
                    o_fail_count++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("header_valid", 32'(want.valid), 32'(i_header_valid));
                    check_field("version_code", 32'(want.ver), 32'(i_version_code));
                    check_field("bitrate_kbps", 32'(want.kbps), 32'(i_bitrate_kbps));
                    check_field("sample_rate_hz", 32'(want.hz), 32'(i_sample_rate_hz));
                    check_field("samples_per_frame", 32'(want.spf),
                                32'(i_samples_per_frame));
                    check_field("padded", 32'(want.pad), 32'(i_padded));
                    check_field("frame_length_bytes", 32'(want.len),
                                32'(i_frame_length_bytes));
                end
            end
            if (i_start && !i_busy) begin
                decoded_q.push_back(decode_header(i_header_word, target_kbps));
            end
            if (i_cfg_wr_en) begin
                target_kbps <= i_cfg_wr_data;
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import mp3hd_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [8:0]  i_cfg_wr_data;
    logic        i_start;
    logic        o_busy;
    logic [31:0] i_header_word;
    logic        o_strobe;
    logic        o_header_valid;
    logic [1:0]  o_version_code;
    logic [8:0]  o_bitrate_kbps;
    logic [15:0] o_sample_rate_hz;
    logic [10:0] o_samples_per_frame;
    logic        o_padded;
    logic [10:0] o_frame_length_bytes;
    int          fail_count;
    int          pending;
    int          burst_left;

    localparam logic [8:0] TARGETS [10] = '{
        9'd0, 9'd320, 9'd8, 9'd511, 9'd160, 9'd64, 9'd144, 9'd257, 9'd32, 9'd0
    };

    always #5 i_clk = ~i_clk;

    mp3_header_decode_core i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_wr_data        (i_cfg_wr_data),
        .i_start              (i_start),
        .o_busy               (o_busy),
        .i_header_word        (i_header_word),
        .o_strobe             (o_strobe),
        .o_header_valid       (o_header_valid),
        .o_version_code       (o_version_code),
        .o_bitrate_kbps       (o_bitrate_kbps),
        .o_sample_rate_hz     (o_sample_rate_hz),
        .o_samples_per_frame  (o_samples_per_frame),
        .o_padded             (o_padded),
        .o_frame_length_bytes (o_frame_length_bytes)
    );

    mp3hd_header_checker i_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_wr_en          (i_cfg_wr_en),
        .i_cfg_wr_data        (i_cfg_wr_data),
        .i_start              (i_start),
        .i_busy               (o_busy),
        .i_header_word        (i_header_word),
        .i_strobe             (o_strobe),
        .i_header_valid       (o_header_valid),
        .i_version_code       (o_version_code),
        .i_bitrate_kbps       (o_bitrate_kbps),
        .i_sample_rate_hz     (o_sample_rate_hz),
        .i_samples_per_frame  (o_samples_per_frame),
        .i_padded             (o_padded),
        .i_frame_length_bytes (o_frame_length_bytes),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    function automatic logic [31:0] make_header(input logic [1:0] ver, input logic [1:0] layer,
                                                input logic [3:0] bri, input logic [1:0] sri,
                                                input logic pad);
        return {11'h7FF, ver, layer, 1'b1, bri, sri, pad, 9'h000};
    endfunction

    function automatic logic [1:0] rand_version();
        case ($urandom_range(0, 2))
            0:       return VER_25;
            1:       return VER_2;
            default: return VER_1;
        endcase
    endfunction

    // mostly well-formed layer III headers with random content, some broken, some noise
    function automatic logic [31:0] rand_header();
        logic [31:0] w;
        int          r;
        w = $urandom;
        r = $urandom_range(0, 99);
        if (r < 90) begin
            w[20:19] = rand_version();
            w[18:17] = LAYER_III;
            w[15:12] = 4'($urandom_range(1, 14));
            w[11:10] = 2'($urandom_range(0, 2));
            if (r >= 80) begin
                case ($urandom_range(0, 4))
                    0: w[20:19] = VER_RSVD;
                    1: w[18:17] = LAYER_III ^ 2'($urandom_range(1, 3));
                    2: w[15:12] = BRI_FREE;
                    3: w[15:12] = BRI_BAD;
                    default: w[11:10] = SRI_RSVD;
                endcase
            end
        end
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(25, 60);
    endfunction

    task automatic send_header(input logic [31:0] w);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
        @(negedge i_clk);
        i_start       <= 1'b1;
        i_header_word <= w;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic write_target(input logic [8:0] t);
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= t;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        #5_000_000;
        $display("mp3_header_decode_core: mismatch");
        $finish;
    end

    initial begin
        burst_left    = 0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_start       = 1'b0;
        i_header_word = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // target at reset value: extremes, reserved codes, other layers
        send_header(make_header(VER_1, LAYER_III, 4'd14, SRI_48K, 1'b1));
        send_header(make_header(VER_1, LAYER_III, 4'd14, SRI_32K, 1'b1));
        send_header(make_header(VER_1, LAYER_III, 4'd1, SRI_44K, 1'b0));
        send_header(make_header(VER_2, LAYER_III, 4'd1, SRI_32K, 1'b0));
        send_header(make_header(VER_2, LAYER_III, 4'd14, SRI_44K, 1'b1));
        send_header(make_header(VER_25, LAYER_III, 4'd14, SRI_32K, 1'b1));
        send_header(make_header(VER_25, LAYER_III, 4'd1, SRI_48K, 1'b0));
        send_header(make_header(VER_RSVD, LAYER_III, 4'd5, SRI_44K, 1'b1));
        for (int l = 0; l < 4; l++) begin
            if (2'(l) != LAYER_III) begin
                send_header(make_header(VER_1, 2'(l), 4'd9, SRI_44K, 1'b1));
            end
        end
        send_header(make_header(VER_1, LAYER_III, BRI_FREE, SRI_44K, 1'b0));
        send_header(make_header(VER_2, LAYER_III, BRI_BAD, SRI_48K, 1'b1));
        send_header(make_header(VER_1, LAYER_III, 4'd7, SRI_RSVD, 1'b1));
        send_header(make_header(VER_25, LAYER_III, BRI_BAD, SRI_RSVD, 1'b0));
        send_header(32'h0000_0000);
        send_header(32'hFFFF_FFFF);
        send_header(make_header(VER_1, LAYER_III, 4'd9, SRI_44K, 1'b1) | 32'h0000_01FF);

        // target bitrate match and miss
        write_target(9'd128);
        send_header(make_header(VER_1, LAYER_III, 4'd9, SRI_44K, 1'b0));
        send_header(make_header(VER_1, LAYER_III, 4'd10, SRI_44K, 1'b1));
        send_header(make_header(VER_2, LAYER_III, 4'd12, SRI_48K, 1'b1));

        foreach (TARGETS[p]) begin
            write_target(TARGETS[p]);
            repeat (173) send_header(rand_header());
        end

        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("mp3_header_decode_core: match");
        end else begin
            $display("mp3_header_decode_core: mismatch");
        end
        $finish;
    end

endmodule
